@@ rtl/amq_pkg.sv @@
`timescale 1ns / 1ps

package amq_pkg;

   // request selector codes
   localparam logic [1:0] CMD_OBSERVE = 2'd0;
   localparam logic [1:0] CMD_CLOSE   = 2'd1;
   localparam logic [1:0] CMD_LOAD    = 2'd2;
   localparam logic [1:0] CMD_QUANT   = 2'd3;

   // result kind codes
   localparam logic KIND_SCALE  = 1'b0;
   localparam logic KIND_WEIGHT = 1'b1;

   localparam logic [31:0] FP_ZERO = 32'h0000_0000;
   localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
   localparam logic [31:0] FP_127  = 32'h42FE_0000;
   localparam logic [31:0] FP_INF  = 32'h7F80_0000;

   localparam int EXP_W     = 12;
   localparam int DIV_STEPS = 25;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // ceil(2^32 / 127): floor(x / 127) = (x * M) >> 32 for any x below 2^25
   localparam logic [25:0] DIV127_MAGIC = 26'd33818641;

   typedef struct packed {
      logic take;
      logic norm_step;
      logic div_init;
      logic div_step;
      logic cmul;
      logic cfin;
      logic den_step;
      logic pack;
      logic mul;
      logic qfin;
      logic emit;
   } amq_cmd_type;

   typedef struct packed {
      logic go_div;
      logic go_mul;
      logic go_emit;
      logic norm_done;
      logic div_const;
      logic den_done;
      logic pack_again;
      logic pack_emit;
      logic out_busy;
   } amq_sts_type;

endpackage

@@ rtl/absmax_int8_quantizer.sv @@
// channel   direction  handshake                 payload
// req_*     in         req_tvalid / req_tready   tuser: cmd; tdata: value
// rsp_*     out        rsp_tvalid / rsp_tready   tuser: kind; tdata: scale_out, q_out
//
// Observe, and load of a non-positive or infinite scale, are handled without leaving idle.
// Quantize goes through normalize, multiply, finish and emit (straight to emit when the
// weight or reciprocal is zero, inf or NaN). Load of a finite positive scale computes
// 1/scale in the one-bit-per-cycle restoring divider. Close computes amax/127 by reciprocal
// multiply, then 1/scale; it goes straight to emit when amax is zero or inf, and emits
// without 1/scale when amax/127 underflows to zero. Subnormal operands add normalization
// shifts, subnormal results add denormal shifts. Reset is synchronous.
// A result waiting on rsp_tready blocks only the next result, not new requests.
`timescale 1ns / 1ps

module absmax_int8_quantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] scale_out, [39:32] q_out
   output logic [0:0]  rsp_tuser    // [0] kind
);

   amq_pkg::amq_cmd_type cmd;
   amq_pkg::amq_sts_type sts;
   logic                 out_kind;
   logic [31:0]          out_scale;
   logic [7:0]           out_q;

   amq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   amq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_cmd   (req_tuser),
      .req_value (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (out_kind),
      .out_scale (out_scale),
      .out_q     (out_q)
   );

   assign rsp_tdata = {out_q, out_scale};
   assign rsp_tuser = out_kind;

`ifndef SYNTHESIS
   // a close always produces a response, so the request side stalls right after it
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == amq_pkg::CMD_CLOSE) |=> !req_tready)
      else $error("request accepted right after close");

   a_scale_q_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == amq_pkg::KIND_SCALE) |-> rsp_tdata[39:32] == 8'd0)
      else $error("scale response with nonzero q_out");

   a_q_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:32] != 8'h80)
      else $error("q_out outside symmetric range");
`endif

endmodule

@@ rtl/amq_ctrl.sv @@
`timescale 1ns / 1ps

module amq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  amq_pkg::amq_sts_type sts,
   output amq_pkg::amq_cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_NORM = 4'd1;
   localparam logic [3:0] S_DINIT = 4'd2;
   localparam logic [3:0] S_DIV = 4'd3;
   localparam logic [3:0] S_DEN = 4'd4;
   localparam logic [3:0] S_PACK = 4'd5;
   localparam logic [3:0] S_MUL = 4'd6;
   localparam logic [3:0] S_QFIN = 4'd7;
   localparam logic [3:0] S_EMIT = 4'd8;
   localparam logic [3:0] S_CMUL = 4'd9;
   localparam logic [3:0] S_CFIN = 4'd10;

   logic [3:0]                 state_ff, state_in;
   logic                       is_mul_ff, is_mul_in;
   logic [amq_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      is_mul_in = is_mul_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (sts.go_div) begin
                  is_mul_in = 1'b0;
                  state_in  = S_NORM;
               end else if (sts.go_mul) begin
                  is_mul_in = 1'b1;
                  state_in  = S_NORM;
               end else if (sts.go_emit) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_NORM: begin
            cmd.norm_step = 1'b1;
            if (sts.norm_done) begin
               state_in = is_mul_ff ? S_MUL : S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            // amax / 127 goes through the reciprocal multiply, not the divider
            if (sts.div_const) begin
               state_in = S_CMUL;
            end else begin
               cnt_in   = amq_pkg::CNT_W'(amq_pkg::DIV_STEPS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DEN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_CMUL: begin
            cmd.cmul = 1'b1;
            state_in = S_CFIN;
         end
         S_CFIN: begin
            cmd.cfin = 1'b1;
            state_in = S_DEN;
         end
         S_DEN: begin
            cmd.den_step = 1'b1;
            if (sts.den_done) begin
               state_in = S_PACK;
            end
         end
         S_PACK: begin
            cmd.pack = 1'b1;
            if (sts.pack_again) begin
               state_in = S_NORM;
            end else if (sts.pack_emit) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_QFIN;
         end
         S_QFIN: begin
            cmd.qfin = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         is_mul_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         is_mul_ff <= is_mul_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ rtl/amq_dp.sv @@
`timescale 1ns / 1ps

module amq_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  amq_pkg::amq_cmd_type cmd,
   output amq_pkg::amq_sts_type sts,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_value,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_kind,
   output logic [31:0]          out_scale,
   output logic [7:0]           out_q
);

   localparam int EW = amq_pkg::EXP_W;

   function automatic logic [23:0] sig_of(input logic [31:0] f);
      sig_of = {(f[30:23] != 8'd0), f[22:0]};
   endfunction

   function automatic logic signed [EW-1:0] exp_of(input logic [31:0] f);
      exp_of = (f[30:23] == 8'd0) ? EW'(1) : $signed(EW'(f[30:23]));
   endfunction

   // architectural state
   logic [31:0] amax_ff, amax_in;
   logic [31:0] scale_ff, scale_in;
   logic [31:0] inv_ff, inv_in;

   // working registers
   logic [23:0]          a_sig_ff, a_sig_in, b_sig_ff, b_sig_in;
   logic signed [EW-1:0] a_exp_ff, a_exp_in, b_exp_ff, b_exp_in;
   logic                 neg_ff, neg_in;
   logic                 to_scale_ff, to_scale_in;
   logic                 emit_after_ff, emit_after_in;
   logic [25:0]          rem_ff, rem_in;
   logic [24:0]          quo_ff, quo_in;
   logic                 sticky_ff, sticky_in;
   logic signed [EW-1:0] rexp_ff, rexp_in;
   logic [18:0]          qd_ff, qd_in;
   logic [47:0]          prod_ff, prod_in;
   logic signed [EW-1:0] pexp_ff, pexp_in;
   logic                 kind_pend_ff, kind_pend_in;
   logic [7:0]           q_pend_ff, q_pend_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_kind_ff, out_kind_in;
   logic [31:0]          out_scale_ff, out_scale_in;
   logic [7:0]           out_q_ff, out_q_in;

   // request decode
   logic v_nan, v_inf, v_zero, inv_zero, inv_inf, amax_zero, amax_inf;
   logic load_pos, load_fin, q_sat_spec;
   logic [7:0] q_spec;

   // divider / packer
   logic        ge;
   logic [25:0] rem_diff;
   logic        d_guard, d_sticky, d_ru;
   logic [31:0] d_res;
   logic signed [EW-1:0] rexp_m1;
   logic [50:0] cprod;

   // quantize finish
   logic        p_hi, p_guard, p_sticky, p_ru;
   logic [23:0] p_sig_raw, p_sig, p_shifted, p_mask;
   logic [24:0] p_sum;
   logic signed [EW-1:0] xq, sh;
   logic        sat;
   logic [8:0]  t;
   logic        rnz;
   logic [9:0]  tp;
   logic [7:0]  mag;

   assign v_nan     = (req_value[30:23] == 8'hFF) && (req_value[22:0] != 23'd0);
   assign v_inf     = (req_value[30:23] == 8'hFF) && (req_value[22:0] == 23'd0);
   assign v_zero    = (req_value[30:0] == 31'd0);
   assign inv_zero  = (inv_ff[30:0] == 31'd0);
   assign inv_inf   = (inv_ff[30:23] == 8'hFF);
   assign amax_zero = (amax_ff == amq_pkg::FP_ZERO);
   assign amax_inf  = (amax_ff[30:23] == 8'hFF);
   assign load_pos  = !req_value[31] && !v_nan && !v_zero;
   assign load_fin  = load_pos && !v_inf;
   // inf times nonzero saturates; NaN, zero and inf times zero give 0
   assign q_sat_spec = !v_nan && ((v_inf && !inv_zero) || (inv_inf && !v_zero));
   assign q_spec     = q_sat_spec ? (req_value[31] ? 8'h81 : 8'h7F) : 8'h00;

   assign sts.go_div  = ((req_cmd == amq_pkg::CMD_CLOSE) && !amax_zero && !amax_inf) ||
                        ((req_cmd == amq_pkg::CMD_LOAD) && load_fin);
   assign sts.go_mul  = (req_cmd == amq_pkg::CMD_QUANT) && !v_nan && !v_zero && !v_inf &&
                        !inv_zero && !inv_inf;
   assign sts.go_emit = ((req_cmd == amq_pkg::CMD_CLOSE) && (amax_zero || amax_inf)) ||
                        ((req_cmd == amq_pkg::CMD_QUANT) && !sts.go_mul);
   assign sts.norm_done  = a_sig_ff[23] && b_sig_ff[23];
   assign sts.div_const  = to_scale_ff;
   assign sts.den_done   = (rexp_ff > EW'(0)) || (quo_ff == 25'd0);
   assign sts.pack_again = to_scale_ff && (d_res != 32'd0);
   assign sts.pack_emit  = emit_after_ff;
   assign sts.out_busy   = out_valid_ff && !out_ready;

   // divider datapath
   assign ge       = (a_sig_ff >= b_sig_ff);
   assign rem_diff = rem_ff - {2'b00, b_sig_ff};
   assign d_guard  = quo_ff[0];
   assign d_sticky = sticky_ff || (rem_ff != 26'd0);
   assign d_ru     = d_guard && (d_sticky || quo_ff[1]);
   assign rexp_m1  = rexp_ff - EW'(1);
   assign cprod    = rem_ff[24:0] * amq_pkg::DIV127_MAGIC;

   always_comb begin
      if (quo_ff == 25'd0) begin
         d_res = 32'd0;
      end else if (rexp_ff >= EW'(255)) begin
         d_res = amq_pkg::FP_INF;
      end else begin
         d_res = {1'b0, rexp_m1[7:0], 23'd0} + {8'd0, quo_ff[24:1]} + 32'(d_ru);
      end
   end

   // product rounding and conversion to int
   assign p_hi      = prod_ff[47];
   assign p_sig_raw = p_hi ? prod_ff[47:24] : prod_ff[46:23];
   assign p_guard   = p_hi ? prod_ff[23] : prod_ff[22];
   assign p_sticky  = p_hi ? (prod_ff[22:0] != 23'd0) : (prod_ff[21:0] != 22'd0);
   assign p_ru      = p_guard && (p_sticky || p_sig_raw[0]);
   assign p_sum     = {1'b0, p_sig_raw} + 25'(p_ru);
   assign p_sig     = p_sum[24] ? p_sum[24:1] : p_sum[23:0];
   // value = p_sig * 2^xq
   assign xq        = pexp_ff - EW'(300) + (p_hi ? EW'(24) : EW'(23)) +
                      (p_sum[24] ? EW'(1) : EW'(0));
   assign sh        = -(xq + EW'(1));
   assign p_shifted = p_sig >> sh[4:0];
   assign p_mask    = (24'd1 << sh[4:0]) - 24'd1;
   // t = floor(2 * |product|)
   assign t         = (sh > EW'(24)) ? 9'd0 : p_shifted[8:0];
   assign rnz       = (p_sig & p_mask) != 24'd0;
   assign sat       = (xq >= -EW'(16)) || (t > 9'd254) || ((t == 9'd254) && rnz);
   assign tp        = {1'b0, t} + 10'd1;
   assign mag       = sat ? 8'd127 : tp[8:1];

   always_comb begin
      amax_in       = amax_ff;
      scale_in      = scale_ff;
      inv_in        = inv_ff;
      a_sig_in      = a_sig_ff;
      a_exp_in      = a_exp_ff;
      b_sig_in      = b_sig_ff;
      b_exp_in      = b_exp_ff;
      neg_in        = neg_ff;
      to_scale_in   = to_scale_ff;
      emit_after_in = emit_after_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      sticky_in     = sticky_ff;
      rexp_in       = rexp_ff;
      qd_in         = qd_ff;
      prod_in       = prod_ff;
      pexp_in       = pexp_ff;
      kind_pend_in  = kind_pend_ff;
      q_pend_in     = q_pend_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_kind_in   = out_kind_ff;
      out_scale_in  = out_scale_ff;
      out_q_in      = out_q_ff;

      if (cmd.take) begin
         case (req_cmd)
            amq_pkg::CMD_OBSERVE: begin
               if (!v_nan && ({1'b0, req_value[30:0]} > amax_ff)) begin
                  amax_in = {1'b0, req_value[30:0]};
               end
            end
            amq_pkg::CMD_CLOSE: begin
               amax_in       = amq_pkg::FP_ZERO;
               kind_pend_in  = amq_pkg::KIND_SCALE;
               q_pend_in     = 8'd0;
               a_sig_in      = sig_of(amax_ff);
               a_exp_in      = exp_of(amax_ff);
               b_sig_in      = sig_of(amq_pkg::FP_127);
               b_exp_in      = exp_of(amq_pkg::FP_127);
               to_scale_in   = 1'b1;
               emit_after_in = 1'b1;
               if (amax_zero) begin
                  scale_in = amq_pkg::FP_ONE;
                  inv_in   = amq_pkg::FP_ONE;
               end else if (amax_inf) begin
                  scale_in = amq_pkg::FP_INF;
                  inv_in   = amq_pkg::FP_ZERO;
               end
            end
            amq_pkg::CMD_LOAD: begin
               scale_in      = req_value;
               a_sig_in      = sig_of(amq_pkg::FP_ONE);
               a_exp_in      = exp_of(amq_pkg::FP_ONE);
               b_sig_in      = sig_of(req_value);
               b_exp_in      = exp_of(req_value);
               to_scale_in   = 1'b0;
               emit_after_in = 1'b0;
               if (!load_fin) begin
                  inv_in = load_pos ? amq_pkg::FP_ZERO : amq_pkg::FP_ONE;
               end
            end
            default: begin
               neg_in       = req_value[31];
               kind_pend_in = amq_pkg::KIND_WEIGHT;
               q_pend_in    = q_spec;
               a_sig_in     = sig_of(req_value);
               a_exp_in     = exp_of(req_value);
               b_sig_in     = sig_of(inv_ff);
               b_exp_in     = exp_of(inv_ff);
            end
         endcase
      end

      // subnormal operands: one bit of left shift per cycle
      if (cmd.norm_step) begin
         if (!a_sig_ff[23]) begin
            a_sig_in = {a_sig_ff[22:0], 1'b0};
            a_exp_in = a_exp_ff - EW'(1);
         end
         if (!b_sig_ff[23]) begin
            b_sig_in = {b_sig_ff[22:0], 1'b0};
            b_exp_in = b_exp_ff - EW'(1);
         end
      end

      if (cmd.div_init) begin
         rem_in    = ge ? {2'b00, a_sig_ff} : {1'b0, a_sig_ff, 1'b0};
         rexp_in   = a_exp_ff - b_exp_ff + EW'(127) - (ge ? EW'(0) : EW'(1));
         quo_in    = 25'd0;
         sticky_in = 1'b0;
      end

      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         if (rem_ff >= {2'b00, b_sig_ff}) begin
            quo_in = {quo_ff[23:0], 1'b1};
            rem_in = {rem_diff[24:0], 1'b0};
         end else begin
            quo_in = {quo_ff[23:0], 1'b0};
            rem_in = {rem_ff[24:0], 1'b0};
         end
      end

      // divisor 127 * 2^17: quotient = floor(x * 128 / 127) = x + floor(x / 127),
      // and since 128 = 1 mod 127 the remainder is x mod 127
      if (cmd.cmul) begin
         qd_in = cprod[50:32];
      end

      if (cmd.cfin) begin
         quo_in = rem_ff[24:0] + {6'd0, qd_ff};
         rem_in = {1'b0, rem_ff[24:0]} - {qd_ff, 7'd0} + {7'd0, qd_ff};
      end

      // subnormal result: right shift into the denormal range
      if (cmd.den_step && !sts.den_done) begin
         quo_in    = {1'b0, quo_ff[24:1]};
         sticky_in = sticky_ff || quo_ff[0];
         rexp_in   = rexp_ff + EW'(1);
      end

      if (cmd.pack) begin
         if (to_scale_ff) begin
            scale_in = d_res;
            if (d_res != 32'd0) begin
               // chain the reciprocal of the new scale
               a_sig_in    = sig_of(amq_pkg::FP_ONE);
               a_exp_in    = exp_of(amq_pkg::FP_ONE);
               b_sig_in    = sig_of(d_res);
               b_exp_in    = exp_of(d_res);
               to_scale_in = 1'b0;
            end else begin
               inv_in = amq_pkg::FP_ONE;
            end
         end else begin
            inv_in = d_res;
         end
      end

      if (cmd.mul) begin
         prod_in = a_sig_ff * b_sig_ff;
         pexp_in = a_exp_ff + b_exp_ff;
      end

      if (cmd.qfin) begin
         q_pend_in = neg_ff ? (8'd0 - mag) : mag;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = kind_pend_ff;
         out_scale_in = scale_ff;
         out_q_in     = q_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amax_ff      <= amq_pkg::FP_ZERO;
         scale_ff     <= amq_pkg::FP_ONE;
         inv_ff       <= amq_pkg::FP_ONE;
         out_valid_ff <= 1'b0;
      end else begin
         amax_ff      <= amax_in;
         scale_ff     <= scale_in;
         inv_ff       <= inv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sig_ff      <= a_sig_in;
      a_exp_ff      <= a_exp_in;
      b_sig_ff      <= b_sig_in;
      b_exp_ff      <= b_exp_in;
      neg_ff        <= neg_in;
      to_scale_ff   <= to_scale_in;
      emit_after_ff <= emit_after_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      sticky_ff     <= sticky_in;
      rexp_ff       <= rexp_in;
      qd_ff         <= qd_in;
      prod_ff       <= prod_in;
      pexp_ff       <= pexp_in;
      kind_pend_ff  <= kind_pend_in;
      q_pend_ff     <= q_pend_in;
      out_kind_ff   <= out_kind_in;
      out_scale_ff  <= out_scale_in;
      out_q_ff      <= out_q_in;
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_scale = out_scale_ff;
   assign out_q     = out_q_ff;

endmodule
